>>> hdl/swtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared widths, result codes and defaults of the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
package swtq_pkg;

    localparam int TIME_W            = 48;
    localparam int ID_W              = 8;
    localparam int DELAY_W           = 32;
    localparam int KIND_W            = 2;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int RESULT_CNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic MODE_SLEEP = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WAKE    = 2'd0,
        KIND_QUEUED  = 2'd1,
        KIND_IGNORED = 2'd2,
        KIND_FULL    = 2'd3
    } t_kind;

    // One pending result, held until the output register is free.
    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wake_time;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/swtq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hdl/sorted_wakeup_timer_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_unit
// Tick counter with a wake-time sorted sleeper table held in one RAM.
// ----------------------------------------------------------------------------
// The sleeper table is a ring buffer in a single RAM with a registered read.
// A tick on an empty table only advances the counter and stays idle. A
// tick on a nonempty table reads and compares the head once per entry, and
// it stops at an entry not yet due, or goes through the flush state when it
// empties the table or reaches the limit of 16 wakeups; a tick with nothing
// due yields no result. A sleep transaction with a positive delay walks back
// from the tail, moving each later entry up one slot, then writes the new
// entry and sends its result from the flush state; an ignored or rejected
// request goes straight to the flush state. Each result also waits for as
// long as the output register is stalled. One transaction is worked on at
// a time, and results wait in an output register while the next one is
// accepted.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue_unit
    import swtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_mode,
    input  wire logic [ID_W-1:0]           i_sleeper_id,
    input  wire logic signed [DELAY_W-1:0] i_delay_ticks,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [KIND_W-1:0]              o_kind,
    output logic [ID_W-1:0]                o_woken_id,
    output logic [TIME_W-1:0]              o_wake_time,
    output logic                           o_last
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = ID_W + TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_TICK_RD,
        S_TICK_CMP,
        S_FLUSH
    } t_state;

    t_state                  r_state;
    logic [TIME_W-1:0]       r_count;
    logic [OW-1:0]           r_occ;
    logic [PW-1:0]           r_head;
    logic [OW-1:0]           r_i;
    logic [RESULT_CNT_W-1:0] r_n;
    logic                    r_have;
    t_result                 r_pend;

    logic                    ram_we;
    logic [PW-1:0]           ram_waddr;
    logic [DW-1:0]           ram_wdata;
    logic [PW-1:0]           ram_raddr;
    logic [DW-1:0]           ram_rdata;
    logic [TIME_W-1:0]       rd_time;
    logic [ID_W-1:0]         rd_id;

    logic                    out_free;
    logic                    out_load;
    logic                    out_last;
    logic                    in_take;
    logic [TIME_W:0]         wake_sum;
    logic [TIME_W-1:0]       wake_sat;
    logic [PW-1:0]           src_idx;
    logic [PW-1:0]           dst_idx;
    logic [PW-1:0]           head_inc;
    logic                    shift_up;
    logic                    due;

    // Ring position: the sum stays below twice the depth, so one subtract wraps it.
    function automatic logic [PW-1:0] wrap(input logic [OW:0] s);
        logic [OW:0] t;
        t = (s >= (OW+1)'(QUEUE_DEPTH)) ? s - (OW+1)'(QUEUE_DEPTH) : s;
        return t[PW-1:0];
    endfunction

    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;

    // The held result goes out from the flush state, or from a tick compare
    // once the next head shows whether it was the final one.
    assign out_load = out_free && r_have && (r_state == S_FLUSH || r_state == S_TICK_CMP);
    assign out_last = (r_state == S_FLUSH) || !due;

    assign wake_sum = {1'b0, r_count} + (TIME_W+1)'(unsigned'(i_delay_ticks));
    assign wake_sat = wake_sum[TIME_W] ? TIME_MAX : wake_sum[TIME_W-1:0];

    assign src_idx  = wrap((OW+1)'(r_head) + (OW+1)'(r_i) - (OW+1)'(1));
    assign dst_idx  = wrap((OW+1)'(r_head) + (OW+1)'(r_i));
    assign head_inc = wrap((OW+1)'(r_head) + (OW+1)'(1));

    assign rd_time  = ram_rdata[TIME_W-1:0];
    assign rd_id    = ram_rdata[DW-1:TIME_W];
    assign shift_up = rd_time > r_pend.wake_time;
    assign due      = rd_time <= r_count;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = dst_idx;
        ram_wdata = {r_pend.id, r_pend.wake_time};
        ram_raddr = r_head;
        case (r_state)
            S_INS_RD: begin
                ram_raddr = src_idx;
            end
            S_INS_CMP: begin
                ram_raddr = src_idx;
                if (shift_up) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                end
            end
            S_INS_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_raddr = r_head;
            end
        endcase
    end

    swtq_ram #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_occ   <= '0;
            r_head  <= '0;
            r_i     <= '0;
            r_n     <= '0;
            r_have  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_valid     <= 1'b1;
                o_kind      <= r_pend.kind;
                o_woken_id  <= r_pend.id;
                o_wake_time <= r_pend.wake_time;
                o_last      <= out_last;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (i_mode == MODE_TICK) begin
                            if (r_count != TIME_MAX) begin
                                r_count <= r_count + TIME_W'(1);
                            end
                            r_n    <= '0;
                            r_have <= 1'b0;
                            if (r_occ != '0) begin
                                r_state <= S_TICK_RD;
                            end
                        end else begin
                            r_pend.id <= i_sleeper_id;
                            r_have    <= 1'b1;
                            if (i_delay_ticks <= 0) begin
                                r_pend.kind      <= KIND_IGNORED;
                                r_pend.wake_time <= '0;
                                r_state          <= S_FLUSH;
                            end else if (r_occ == OW'(QUEUE_DEPTH)) begin
                                r_pend.kind      <= KIND_FULL;
                                r_pend.wake_time <= wake_sat;
                                r_state          <= S_FLUSH;
                            end else begin
                                r_pend.kind      <= KIND_QUEUED;
                                r_pend.wake_time <= wake_sat;
                                r_i              <= r_occ;
                                r_state          <= (r_occ == '0) ? S_INS_WR : S_INS_RD;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    // Entries due later than the new one move up a slot.
                    if (shift_up) begin
                        r_i     <= r_i - OW'(1);
                        r_state <= (r_i == OW'(1)) ? S_INS_WR : S_INS_RD;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_occ   <= r_occ + OW'(1);
                    r_state <= S_FLUSH;
                end
                S_TICK_RD: begin
                    r_state <= S_TICK_CMP;
                end
                S_TICK_CMP: begin
                    // The held result is sent only once the next head tells
                    // whether it was the final one of this tick.
                    if (out_free || !r_have) begin
                        if (due) begin
                            r_pend.kind      <= KIND_WAKE;
                            r_pend.id        <= rd_id;
                            r_pend.wake_time <= rd_time;
                            r_have           <= 1'b1;
                            r_head           <= head_inc;
                            r_occ            <= r_occ - OW'(1);
                            r_n              <= r_n + RESULT_CNT_W'(1);
                            if (r_n == RESULT_CNT_W'(MAX_RESULTS - 1) || r_occ == OW'(1)) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_state <= S_TICK_RD;
                            end
                        end else begin
                            r_have  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("occupancy above table depth");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RESULT_CNT_W'(MAX_RESULTS))
        else $error("tick popped more entries than allowed");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("tick counter went backward");

    a_ins_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_RD || r_state == S_INS_CMP) |-> (r_i != '0 && r_i <= r_occ))
        else $error("insert walk outside occupied range");

    a_flush_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> r_have)
        else $error("flush without a held result");

endmodule
`default_nettype wire

>>> dv/sorted_wakeup_timer_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue_unit_tb
// Self-checking bench for the sorted wakeup timer queue. A clocked driver
// feeds sleep and tick transactions from a stimulus queue, a software copy of
// the alarm table predicts every result, and a clocked monitor compares each
// result transaction field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_wakeup_timer_queue_unit_tb;
    import swtq_pkg::*;

    localparam int   MAX_REPORTS = 40;

    typedef struct {
        bit                        pause;
        logic                      mode;
        logic [ID_W-1:0]           id;
        logic signed [DELAY_W-1:0] delay;
        int                        idle_pct;
        int                        stall_pct;
    } t_stim_item;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] wake_time;
        logic              last;
    } t_alarm_event;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_mode = MODE_TICK;
    logic [ID_W-1:0]           i_sleeper_id = '0;
    logic signed [DELAY_W-1:0] i_delay_ticks = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [KIND_W-1:0]         o_kind;
    logic [ID_W-1:0]           o_woken_id;
    logic [TIME_W-1:0]         o_wake_time;
    logic                      o_last;

    t_stim_item   stim_q[$];
    t_alarm_event alarm_events_due[$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           ph_idle = 0;
    int           ph_stall = 0;

    // Software copy of the sleeper table, kept sorted by wake time.
    logic [TIME_W-1:0] model_ticks = '0;
    logic [TIME_W-1:0] model_wake[QUEUE_DEPTH_DEF];
    logic [ID_W-1:0]   model_id[QUEUE_DEPTH_DEF];
    int                model_fill = 0;

    sorted_wakeup_timer_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_sleeper_id  (i_sleeper_id),
        .i_delay_ticks (i_delay_ticks),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_woken_id    (o_woken_id),
        .o_wake_time   (o_wake_time),
        .o_last        (o_last)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Applies one accepted transaction to the table copy and queues the
    // results that the block must produce for it.
    task automatic step_alarm_model(input logic mode, input logic [ID_W-1:0] id,
                                    input logic signed [DELAY_W-1:0] delay);
        t_alarm_event      ev;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] wake;
        int                pos;
        int                n;
        int                i;
        if (mode == MODE_SLEEP) begin
            ev.id = id;
            ev.last = 1'b1;
            if (delay <= 0) begin
                ev.kind = KIND_IGNORED;
                ev.wake_time = '0;
            end else begin
                sum = {1'b0, model_ticks} + (TIME_W+1)'(delay[DELAY_W-2:0]);
                wake = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                ev.wake_time = wake;
                if (model_fill >= QUEUE_DEPTH_DEF) begin
                    ev.kind = KIND_FULL;
                end else begin
                    ev.kind = KIND_QUEUED;
                    // Equal wake times go behind the ones already waiting.
                    pos = 0;
                    while (pos < model_fill && model_wake[pos] <= wake) pos++;
                    for (i = model_fill; i > pos; i--) begin
                        model_wake[i] = model_wake[i-1];
                        model_id[i] = model_id[i-1];
                    end
                    model_wake[pos] = wake;
                    model_id[pos] = id;
                    model_fill++;
                end
            end
            alarm_events_due.push_back(ev);
        end else begin
            n = 0;
            if (model_ticks != TIME_MAX) model_ticks++;
            while (n < MAX_RESULTS && model_fill > 0 && model_wake[0] <= model_ticks) begin
                ev.kind = KIND_WAKE;
                ev.id = model_id[0];
                ev.wake_time = model_wake[0];
                ev.last = !((n + 1 < MAX_RESULTS) && (model_fill > 1) &&
                            (model_wake[1] <= model_ticks));
                alarm_events_due.push_back(ev);
                n++;
                for (i = 1; i < model_fill; i++) begin
                    model_wake[i-1] = model_wake[i];
                    model_id[i-1] = model_id[i];
                end
                model_fill--;
            end
        end
    endtask

    // Driver: predicts on acceptance, then loads the next transaction.
    always @(posedge i_clk) begin
        t_stim_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                step_alarm_model(i_mode, i_sleeper_id, i_delay_ticks);
            end
            if (!i_valid || !o_stall) begin
                if (stim_q.size() > 0 && stim_q[0].pause && alarm_events_due.size() == 0) begin
                    void'(stim_q.pop_front());
                end
                if (stim_q.size() == 0 || stim_q[0].pause ||
                    $urandom_range(0, 99) < send_idle_pct) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = stim_q.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= nxt.mode;
                    i_sleeper_id <= nxt.id;
                    i_delay_ticks <= nxt.delay;
                    send_idle_pct <= nxt.idle_pct;
                    recv_stall_pct <= nxt.stall_pct;
                end
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_alarm_event ev;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (alarm_events_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d id %0d time %0d",
                                              o_kind, o_woken_id, o_wake_time));
                end else begin
                    ev = alarm_events_due.pop_front();
                    if (o_kind !== ev.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", o_kind, ev.kind));
                    if (o_woken_id !== ev.id)
                        report_mismatch($sformatf("woken_id %0d, expected %0d",
                                                  o_woken_id, ev.id));
                    if (o_wake_time !== ev.wake_time)
                        report_mismatch($sformatf("wake_time %0d, expected %0d",
                                                  o_wake_time, ev.wake_time));
                    if (o_last !== ev.last)
                        report_mismatch($sformatf("last %0b, expected %0b", o_last, ev.last));
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic void push_item(input bit pause, input logic mode,
                                      input logic [ID_W-1:0] id,
                                      input logic signed [DELAY_W-1:0] delay);
        t_stim_item it;
        it.pause = pause;
        it.mode = mode;
        it.id = id;
        it.delay = delay;
        it.idle_pct = ph_idle;
        it.stall_pct = ph_stall;
        stim_q.push_back(it);
    endfunction

    // Mostly short delays so that ties and wakeups are frequent, with a few
    // nonpositive requests and a rare long sleep that lingers in the table.
    function automatic logic signed [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return '0;
        if (r < 14) return $urandom | 32'h8000_0000;
        if (r < 16) return $urandom_range(25, 400);
        return $urandom_range(1, 16);
    endfunction

    initial begin
        int idle_tab[4];
        int stall_tab[4];
        int p;
        int n;
        int k;
        int burst;
        idle_tab = '{0, 52, 0, 14};
        stall_tab = '{0, 0, 52, 14};

        // Directed: empty tick, ignored requests at the delay extremes, a sleep
        // that never comes due, then a full table with ties and a reject.
        push_item(0, MODE_TICK, '0, '0);
        push_item(0, MODE_SLEEP, 8'h00, 32'sd0);
        push_item(0, MODE_SLEEP, 8'hFF, -32'sd1);
        push_item(0, MODE_SLEEP, 8'hA5, 32'h8000_0000);
        push_item(0, MODE_SLEEP, 8'h5A, 32'h7FFF_FFFF);
        for (k = 0; k < QUEUE_DEPTH_DEF - 1; k++) begin
            push_item(0, MODE_SLEEP, (k == 0) ? 8'h00 : 8'(k * 17), ((k * 7) % 4) + 1);
        end
        push_item(0, MODE_SLEEP, 8'hFF, 32'sd1);
        repeat (4) push_item(0, MODE_TICK, '0, '0);

        for (p = 0; p < 4; p++) begin
            ph_idle = idle_tab[p];
            ph_stall = stall_tab[p];
            push_item(1, MODE_TICK, '0, '0);
            n = 0;
            while (n < 66) begin
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18)
                                                   : $urandom_range(1, 5);
                repeat (burst) begin
                    push_item(0, MODE_SLEEP, 8'($urandom_range(0, 255)), pick_delay());
                    n++;
                end
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    push_item(0, MODE_TICK, 8'($urandom_range(0, 255)), $urandom);
                    n++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_valid || alarm_events_due.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (alarm_events_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", alarm_events_due.size()));
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", alarm_events_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
